[sv/hbi_pkg.sv]
// Package for the hash bucket index block: payload and command types,
// constants and the one-at-a-time mixing functions. No dependencies.
`default_nettype none
package hbi_pkg;

  localparam int HASH_W    = 32;
  localparam int IDX_W     = 16;
  localparam int CFG_W     = 17;
  localparam int DIV_STEPS = HASH_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0] BUCKETS_RESET = CFG_W'(256);
  localparam logic [CFG_W-1:0] BUCKETS_MAX   = CFG_W'(65536);

  localparam int MIX_SL  = 10;
  localparam int MIX_SR  = 6;
  localparam int FIN_SL1 = 3;
  localparam int FIN_SR  = 11;
  localparam int FIN_SL2 = 15;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [HASH_W-1:0] full_hash;
    logic [IDX_W-1:0]  bucket_index;
  } out_t;

  typedef struct packed {
    logic byte_take;
    logic load_fin;
    logic div_step;
    logic out_load;
  } cmd_t;

  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] t;
    t = h + {{(HASH_W-8){1'b0}}, b};
    t = t + (t << MIX_SL);
    t = t ^ (t >> MIX_SR);
    return t;
  endfunction

  function automatic logic [HASH_W-1:0] finish_mix(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] t;
    t = h + (h << FIN_SL1);
    t = t ^ (t >> FIN_SR);
    t = t + (t << FIN_SL2);
    return t;
  endfunction

endpackage
`default_nettype wire

[sv/hbi_datapath.sv]
// Datapath: running hash, finishing mix, bit-serial remainder unit,
// bucket count register and result register. Depends on hbi_pkg.
`default_nettype none
module hbi_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire hbi_pkg::in_t             in_data,
  input  wire hbi_pkg::cmd_t            cmd,
  input  wire logic                     cfg_wr_en,
  input  wire logic [hbi_pkg::CFG_W-1:0] cfg_wr_data,
  output hbi_pkg::out_t                 out_data
);
  import hbi_pkg::*;

  logic [HASH_W-1:0] run_r, run_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [HASH_W-1:0] dvd_r, dvd_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [CFG_W-1:0]  cfg_r, cfg_nxt;
  out_t              out_r, out_nxt;
  logic [CFG_W-1:0]  divisor;
  logic [CFG_W-1:0]  rem_sh;
  logic [HASH_W-1:0] mixed;
  logic [HASH_W-1:0] fin;

  always_comb begin
    if (cfg_r == '0) begin
      divisor = CFG_W'(1);
    end else if (cfg_r > BUCKETS_MAX) begin
      divisor = BUCKETS_MAX;
    end else begin
      divisor = cfg_r;
    end
  end

  assign mixed  = mix_byte(run_r, in_data.key_byte);
  assign fin    = finish_mix(hash_r);
  assign rem_sh = {rem_r, dvd_r[HASH_W-1]};

  always_comb begin
    run_nxt  = run_r;
    hash_nxt = hash_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    out_nxt  = out_r;
    cfg_nxt  = cfg_wr_en ? cfg_wr_data : cfg_r;
    if (cmd.byte_take) begin
      if (in_data.last_byte) begin
        run_nxt  = '0;
        hash_nxt = mixed;
      end else begin
        run_nxt = mixed;
      end
    end
    if (cmd.load_fin) begin
      hash_nxt = fin;
      dvd_nxt  = fin;
      rem_nxt  = '0;
    end
    if (cmd.div_step) begin
      dvd_nxt = dvd_r << 1;
      if (rem_sh >= divisor) begin
        rem_nxt = IDX_W'(rem_sh - divisor);
      end else begin
        rem_nxt = rem_sh[IDX_W-1:0];
      end
    end
    if (cmd.out_load) begin
      out_nxt.full_hash    = hash_r;
      out_nxt.bucket_index = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
      cfg_r <= BUCKETS_RESET;
    end else begin
      run_r <= run_nxt;
      cfg_r <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    out_r  <= out_nxt;
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

[sv/hbi_ctrl.sv]
// Controller: sequences byte transfers, finishing mix, remainder steps and
// the result register handshake. Depends on hbi_pkg.
`default_nettype none
module hbi_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output hbi_pkg::cmd_t      cmd
);
  import hbi_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIN  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             in_xfer;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.byte_take = 1'b1;
          if (in_last) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        cmd.load_fin = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result register loaded over a pending transfer");

  a_last_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_last) |=> (state_r == S_FIN))
    else $error("final byte did not start the finishing mix");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_W'(DIV_STEPS - 1)) |=> (state_r == S_DONE))
    else $error("remainder steps did not end on time");

  a_fin_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (state_r == S_DIV && cnt_r == '0))
    else $error("remainder unit not started after finishing mix");

endmodule
`default_nettype wire

[sv/hash_bucket_index.sv]
// Top level of the hash bucket index block: joins controller and datapath.
// Depends on hbi_pkg, hbi_ctrl and hbi_datapath.
//
// Usage: key bytes arrive on the in_ channel one per transfer, with
// last_byte set on the final byte of each key. Each transfer with
// last_byte clear is taken without a stall, so a key streams at one byte per
// cycle. A final byte yields one result on the out_ channel: the finished
// one-at-a-time hash and that hash modulo the bucket count.
// From the final-byte transfer to out_valid the block runs the finishing
// mix, the bit-serial remainder unit (one quotient bit a cycle) and the
// load of the result register. During that time in_stall is high.
// The result register frees the input side: bytes of the next key are taken
// while a result waits under out_stall. A second result waits in the
// remainder unit until the register is emptied, holding in_stall high.
// cfg_wr_en/cfg_wr_data write the bucket count (0 acts as 1, above 65536
// acts as 65536); write only while the block is idle.
// Reset (rst_n low, synchronous) clears the running hash, empties the
// result register and sets the bucket count to 256.
`default_nettype none
module hash_bucket_index (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire hbi_pkg::in_t              in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output hbi_pkg::out_t                  out_data,
  input  wire logic                      cfg_wr_en,
  input  wire logic [hbi_pkg::CFG_W-1:0] cfg_wr_data
);
  import hbi_pkg::*;

  cmd_t cmd;

  hbi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_byte),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  hbi_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cmd         (cmd),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire
